FILE: hw/rtl/sfdi_pkg.sv
// ----------------------------------------------------------------------------
// sfdi_pkg
// Shared types and constants of the stereo feedback delay with interpolation.
// ----------------------------------------------------------------------------
package sfdi_pkg;

  // fixed-point unity and field widths
  localparam int UNITY_Q16 = 65536;
  localparam int FRAC_W    = 16;
  localparam int FB_W      = 15;
  localparam int WET_W     = 17;
  localparam int DELAY_W   = 16;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // register map, word index
  typedef enum logic [1:0] {
    REG_DELAY_WHOLE,
    REG_DELAY_FRACTION,
    REG_FEEDBACK_GAIN,
    REG_WET_GAIN
  } sfdi_reg_t;

  // item sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_MIX,
    ST_WB
  } sfdi_state_t;

  // stage enables from the sequencer to the channel datapaths
  typedef struct packed {
    logic mul_en;
    logic sum_en;
    logic mix_en;
    logic commit;
  } sfdi_stage_t;

endpackage

FILE: hw/rtl/sfdi_in_if.sv
// ----------------------------------------------------------------------------
// sfdi_in_if
// Input channel: one stereo frame per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfdi_in_if #(
  parameter int SAMPLE_BITS = 24
) ();

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);

endinterface

FILE: hw/rtl/sfdi_out_if.sv
// ----------------------------------------------------------------------------
// sfdi_out_if
// Result channel: one mixed stereo frame per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfdi_out_if #(
  parameter int SAMPLE_BITS = 24
) ();

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);

endinterface

FILE: hw/rtl/sfdi_store.sv
// ----------------------------------------------------------------------------
// sfdi_store
// Circular sample store: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
module sfdi_store #(
  parameter int DEPTH = 65536,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // two registered read ports, loaded while rd_en is high
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

FILE: hw/rtl/sfdi_chan.sv
// ----------------------------------------------------------------------------
// sfdi_chan
// One channel's arithmetic: tap interpolation, feedback into the store and
// the dry/wet mix, with a multiplier rank in the mul and in the mix stage.
// ----------------------------------------------------------------------------
module sfdi_chan #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                             clk,
  input  sfdi_pkg::sfdi_stage_t            stage,
  input  logic signed [SAMPLE_BITS-1:0]    x,
  input  logic signed [SAMPLE_BITS-1:0]    y0,
  input  logic signed [SAMPLE_BITS-1:0]    y1,
  input  logic [sfdi_pkg::FRAC_W-1:0]      frac,
  input  logic [sfdi_pkg::FB_W-1:0]        fb,
  input  logic [sfdi_pkg::WET_W-1:0]       wet,
  input  logic [sfdi_pkg::WET_W-1:0]       dry,
  output logic signed [SAMPLE_BITS-1:0]    stored,
  output logic signed [SAMPLE_BITS-1:0]    mixed
);

  localparam int SW = SAMPLE_BITS;
  localparam int GW = sfdi_pkg::WET_W + 1;     // 17-bit gain as signed
  localparam int PW = SW + GW;                 // sample times Q16 gain
  localparam int FW = SW + sfdi_pkg::FB_W + 1; // sample times feedback gain
  localparam int HALF16 = sfdi_pkg::UNITY_Q16 / 2;
  localparam int HALF15 = sfdi_pkg::UNITY_Q16 / 4;

  logic [SW-1:0] sat_max;
  logic [SW-1:0] sat_min;

  logic [sfdi_pkg::FRAC_W:0] frac_c;
  logic signed [PW-1:0] p0_nxt, p0_r;
  logic signed [PW-1:0] p1_nxt, p1_r;
  logic [PW:0]          isum;
  logic signed [SW-1:0] delayed_nxt, delayed_r;
  logic signed [FW-1:0] pfb_nxt, pfb_r;
  logic signed [PW-1:0] pdry_nxt, pdry_r;
  logic signed [PW-1:0] pwet_nxt, pwet_r;
  logic [FW-1:0]        fsum;
  logic [SW:0]          fb_add;
  logic [SW+1:0]        st_sum;
  logic [PW:0]          msum;
  logic [SW+2:0]        mix_q;

  assign sat_max = {1'b0, {(SW-1){1'b1}}};
  assign sat_min = {1'b1, {(SW-1){1'b0}}};

  // interpolation weights: tap d gets one minus fraction
  assign frac_c = (sfdi_pkg::FRAC_W+1)'(sfdi_pkg::UNITY_Q16) - {1'b0, frac};
  assign p0_nxt = y0 * $signed({1'b0, frac_c});
  assign p1_nxt = y1 * $signed({2'b00, frac});

  always_ff @(posedge clk) begin
    if (stage.mul_en) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
    end
  end

  // round half up and drop 16 fraction bits
  assign isum = {p0_r[PW-1], p0_r} + {p1_r[PW-1], p1_r} + (PW+1)'(HALF16);
  assign delayed_nxt = isum[SW+15:16];

  always_ff @(posedge clk) begin
    if (stage.sum_en) begin
      delayed_r <= delayed_nxt;
    end
  end

  // feedback and mix products
  assign pfb_nxt  = delayed_r * $signed({1'b0, fb});
  assign pdry_nxt = x * $signed({1'b0, dry});
  assign pwet_nxt = delayed_r * $signed({1'b0, wet});

  always_ff @(posedge clk) begin
    if (stage.mix_en) begin
      pfb_r  <= pfb_nxt;
      pdry_r <= pdry_nxt;
      pwet_r <= pwet_nxt;
    end
  end

  // store value: input plus rounded feedback, saturated
  assign fsum   = pfb_r + FW'(HALF15);
  assign fb_add = fsum[FW-1:15];
  assign st_sum = {{2{x[SW-1]}}, x} + {fb_add[SW], fb_add};

  always_comb begin
    if ((st_sum[SW+1:SW-1] == '0) || (st_sum[SW+1:SW-1] == '1)) begin
      stored = st_sum[SW-1:0];
    end else if (st_sum[SW+1]) begin
      stored = sat_min;
    end else begin
      stored = sat_max;
    end
  end

  // output mix: rounded dry plus wet, saturated
  assign msum  = {pdry_r[PW-1], pdry_r} + {pwet_r[PW-1], pwet_r} + (PW+1)'(HALF16);
  assign mix_q = msum[PW:16];

  always_comb begin
    if ((mix_q[SW+2:SW-1] == '0) || (mix_q[SW+2:SW-1] == '1)) begin
      mixed = mix_q[SW-1:0];
    end else if (mix_q[SW+2]) begin
      mixed = sat_min;
    end else begin
      mixed = sat_max;
    end
  end

endmodule

FILE: hw/rtl/sfdi_ctrl.sv
// ----------------------------------------------------------------------------
// sfdi_ctrl
// Item sequencer, write position, fill count and tap address generation.
// ----------------------------------------------------------------------------
module sfdi_ctrl #(
  parameter int STORE_DEPTH = 65536
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_fire,
  input  logic                             out_free,
  input  logic                             clear_fill,
  input  logic [sfdi_pkg::DELAY_W-1:0]     delay_whole,
  output logic                             in_ready,
  output sfdi_pkg::sfdi_stage_t            stage,
  output logic [$clog2(STORE_DEPTH)-1:0]   raddr0,
  output logic [$clog2(STORE_DEPTH)-1:0]   raddr1,
  output logic [$clog2(STORE_DEPTH)-1:0]   waddr,
  output logic                             tap_ok0_r,
  output logic                             tap_ok1_r
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int TW = (CW > sfdi_pkg::DELAY_W + 1) ? CW : sfdi_pkg::DELAY_W + 1;
  localparam int XW = TW + 1;

  sfdi_pkg::sfdi_state_t state_r, state_nxt;

  logic [AW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [XW-1:0] d_ext;
  logic [XW-1:0] d_lim;
  logic [XW-1:0] d_cl;
  logic [XW-1:0] back0;
  logic [XW-1:0] back1;
  logic [XW-1:0] fill_x;

  // wrap position minus distance back into the store
  function automatic logic [AW-1:0] tap_addr(input logic [XW-1:0] wp_x,
                                             input logic [XW-1:0] back);
    logic [XW-1:0] s;
    s = wp_x + XW'(STORE_DEPTH) - back;
    if (s >= XW'(STORE_DEPTH)) begin
      s = s - XW'(STORE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // clamp delay so the second tap stays inside the store
  assign d_ext  = XW'(delay_whole);
  assign d_lim  = XW'(STORE_DEPTH - 2);
  assign d_cl   = (d_ext > d_lim) ? d_lim : d_ext;
  assign back0  = d_cl + XW'(1);
  assign back1  = d_cl + XW'(2);
  assign fill_x = XW'(fill_r);

  assign raddr0 = tap_addr(XW'(wp_r), back0);
  assign raddr1 = tap_addr(XW'(wp_r), back1);
  assign waddr  = wp_r;

  // taps older than the fill count read as zero
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tap_ok0_r <= (d_cl < fill_x);
      tap_ok1_r <= (back0 < fill_x);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sfdi_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = sfdi_pkg::ST_MUL;
      end
      sfdi_pkg::ST_MUL: state_nxt = sfdi_pkg::ST_SUM;
      sfdi_pkg::ST_SUM: state_nxt = sfdi_pkg::ST_MIX;
      sfdi_pkg::ST_MIX: state_nxt = sfdi_pkg::ST_WB;
      sfdi_pkg::ST_WB: begin
        if (out_free) state_nxt = sfdi_pkg::ST_IDLE;
      end
      default: state_nxt = sfdi_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    stage    = '0;
    case (state_r)
      sfdi_pkg::ST_IDLE: in_ready = 1'b1;
      sfdi_pkg::ST_MUL:  stage.mul_en = 1'b1;
      sfdi_pkg::ST_SUM:  stage.sum_en = 1'b1;
      sfdi_pkg::ST_MIX:  stage.mix_en = 1'b1;
      sfdi_pkg::ST_WB:   stage.commit = out_free;
      default: begin
        in_ready = 1'b0;
        stage    = '0;
      end
    endcase
  end

  // write position and fill count
  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (stage.commit) begin
      wp_nxt = (wp_r == AW'(STORE_DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (fill_r != CW'(STORE_DEPTH)) begin
        fill_nxt = fill_r + CW'(1);
      end
    end
    if (clear_fill) begin
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfdi_pkg::ST_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
    end
  end

endmodule

FILE: hw/rtl/stereo_feedback_delay_interp.sv
// ----------------------------------------------------------------------------
// stereo_feedback_delay_interp
// Stereo feedback delay line with linear interpolation between two taps.
// ----------------------------------------------------------------------------
// an accepted item passes the store read, three arithmetic stages and the
//   write-back before the result register is loaded; a new item is taken
//   only after the last one is written back, as items are done one at a time
// a full result register that is not taken holds the write-back stage
// reset: sync active low; the store reads as zero through a fill count,
//   with no clearing pass; a delay register write empties it the same way
module stereo_feedback_delay_interp #(
  parameter int STORE_DEPTH = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sfdi_in_if.sink                       in_chan,
  sfdi_out_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfdi_pkg::PADDR_W-1:0]  paddr,
  input  logic [sfdi_pkg::PDATA_W-1:0]  pwdata,
  output logic [sfdi_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int SW = SAMPLE_BITS;
  localparam int AW = $clog2(STORE_DEPTH);

  // configuration registers
  logic [sfdi_pkg::DELAY_W-1:0] delay_whole_r;
  logic [sfdi_pkg::FRAC_W-1:0]  delay_fraction_r;
  logic [sfdi_pkg::FB_W-1:0]    feedback_gain_r;
  logic [sfdi_pkg::WET_W-1:0]   wet_gain_r;
  logic [sfdi_pkg::WET_W-1:0]   wet_c;
  logic [sfdi_pkg::WET_W-1:0]   dry_c;

  logic                 cfg_wr;
  sfdi_pkg::sfdi_reg_t  cfg_idx;
  logic                 clear_fill;

  logic                  in_ready;
  logic                  in_fire;
  logic                  out_free;
  sfdi_pkg::sfdi_stage_t stage;
  logic [AW-1:0]         raddr0;
  logic [AW-1:0]         raddr1;
  logic [AW-1:0]         waddr;
  logic                  tap_ok0_r;
  logic                  tap_ok1_r;

  logic [2*SW-1:0]      rdata0;
  logic [2*SW-1:0]      rdata1;
  logic [2*SW-1:0]      wdata;
  logic signed [SW-1:0] xl_r, xr_r;
  logic signed [SW-1:0] yl0, yl1, yr0, yr1;
  logic signed [SW-1:0] stored_l, stored_r;
  logic signed [SW-1:0] mixed_l, mixed_r;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [SW-1:0] left_out_r;
  logic signed [SW-1:0] right_out_r;

  // register writes
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign cfg_idx    = sfdi_pkg::sfdi_reg_t'(paddr[3:2]);
  assign clear_fill = cfg_wr && ((cfg_idx == sfdi_pkg::REG_DELAY_WHOLE) ||
                                 (cfg_idx == sfdi_pkg::REG_DELAY_FRACTION));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_whole_r    <= '0;
      delay_fraction_r <= '0;
      feedback_gain_r  <= '0;
      wet_gain_r       <= sfdi_pkg::WET_W'(sfdi_pkg::UNITY_Q16);
    end else if (cfg_wr) begin
      case (cfg_idx)
        sfdi_pkg::REG_DELAY_WHOLE:    delay_whole_r    <= pwdata[sfdi_pkg::DELAY_W-1:0];
        sfdi_pkg::REG_DELAY_FRACTION: delay_fraction_r <= pwdata[sfdi_pkg::FRAC_W-1:0];
        sfdi_pkg::REG_FEEDBACK_GAIN:  feedback_gain_r  <= pwdata[sfdi_pkg::FB_W-1:0];
        sfdi_pkg::REG_WET_GAIN:       wet_gain_r       <= pwdata[sfdi_pkg::WET_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (cfg_idx)
      sfdi_pkg::REG_DELAY_WHOLE:    prdata = sfdi_pkg::PDATA_W'(delay_whole_r);
      sfdi_pkg::REG_DELAY_FRACTION: prdata = sfdi_pkg::PDATA_W'(delay_fraction_r);
      sfdi_pkg::REG_FEEDBACK_GAIN:  prdata = sfdi_pkg::PDATA_W'(feedback_gain_r);
      sfdi_pkg::REG_WET_GAIN:       prdata = sfdi_pkg::PDATA_W'(wet_gain_r);
      default:                      prdata = '0;
    endcase
  end

  // wet gain clamped to unity, dry is the rest
  assign wet_c = (wet_gain_r > sfdi_pkg::WET_W'(sfdi_pkg::UNITY_Q16)) ?
                 sfdi_pkg::WET_W'(sfdi_pkg::UNITY_Q16) : wet_gain_r;
  assign dry_c = sfdi_pkg::WET_W'(sfdi_pkg::UNITY_Q16) - wet_c;

  // input handshake
  assign in_fire       = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      xl_r <= in_chan.left_in;
      xr_r <= in_chan.right_in;
    end
  end

  sfdi_ctrl #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .out_free    (out_free),
    .clear_fill  (clear_fill),
    .delay_whole (delay_whole_r),
    .in_ready    (in_ready),
    .stage       (stage),
    .raddr0      (raddr0),
    .raddr1      (raddr1),
    .waddr       (waddr),
    .tap_ok0_r   (tap_ok0_r),
    .tap_ok1_r   (tap_ok1_r)
  );

  // one store word holds the left and right samples
  sfdi_store #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (2 * SW)
  ) u_store (
    .clk    (clk),
    .rd_en  (in_fire),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1),
    .wr_en  (stage.commit),
    .waddr  (waddr),
    .wdata  (wdata)
  );

  // taps not yet written since the last clear read as zero
  assign yl0 = tap_ok0_r ? rdata0[2*SW-1:SW] : '0;
  assign yr0 = tap_ok0_r ? rdata0[SW-1:0]    : '0;
  assign yl1 = tap_ok1_r ? rdata1[2*SW-1:SW] : '0;
  assign yr1 = tap_ok1_r ? rdata1[SW-1:0]    : '0;

  sfdi_chan #(
    .SAMPLE_BITS (SW)
  ) u_chan_l (
    .clk    (clk),
    .stage  (stage),
    .x      (xl_r),
    .y0     (yl0),
    .y1     (yl1),
    .frac   (delay_fraction_r),
    .fb     (feedback_gain_r),
    .wet    (wet_c),
    .dry    (dry_c),
    .stored (stored_l),
    .mixed  (mixed_l)
  );

  sfdi_chan #(
    .SAMPLE_BITS (SW)
  ) u_chan_r (
    .clk    (clk),
    .stage  (stage),
    .x      (xr_r),
    .y0     (yr0),
    .y1     (yr1),
    .frac   (delay_fraction_r),
    .fb     (feedback_gain_r),
    .wet    (wet_c),
    .dry    (dry_c),
    .stored (stored_r),
    .mixed  (mixed_r)
  );

  assign wdata = {stored_l, stored_r};

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (stage.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage.commit) begin
      left_out_r  <= mixed_l;
      right_out_r <= mixed_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.left_out  = left_out_r;
  assign out_chan.right_out = right_out_r;

endmodule

FILE: hw/rtl/sfdi_checker.sv
// ----------------------------------------------------------------------------
// sfdi_checker
// Port-level checks of the delay block, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sfdi_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pready
);

  logic       in_fire;
  logic       out_fire;
  logic [1:0] pend_r, pend_nxt;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // items accepted and not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (in_fire && !out_fire) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_fire && out_fire) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // a result waiting for the sink stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // no result without an item behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without an accepted item");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second item taken while one is in work");

  // configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind stereo_feedback_delay_interp sfdi_checker u_sfdi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .pready    (pready)
);

FILE: verif/tb_stereo_feedback_delay_interp.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_feedback_delay_interp
// Self-checking bench for the stereo feedback delay: stereo frames go in
// through a bursty sender, mixed frames come back through a receiver that
// stalls, and every result is compared with a local model of the delay
// stores, the interpolation, the feedback and the wet/dry mix.
// ----------------------------------------------------------------------------
module tb_stereo_feedback_delay_interp;

  localparam int     HIST_DEPTH     = 65536;
  localparam int     SAMPLE_W       = 24;
  localparam longint SAMPLE_MAX     = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN     = -SAMPLE_MAX - 1;
  localparam int     SETTLE_CYCLES  = 12;
  localparam int     LONG_STALL     = 400;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     SEGMENTS       = 14;
  localparam int     PRINT_CAP      = 40;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } stereo_frame_t;

  logic clk;
  logic rst_n;

  // configuration port
  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [sfdi_pkg::PADDR_W-1:0]   paddr   = '0;
  logic [sfdi_pkg::PDATA_W-1:0]   pwdata  = '0;
  logic [sfdi_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;

  sfdi_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_bus ();
  sfdi_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_bus ();

  stereo_feedback_delay_interp #(
    .STORE_DEPTH(HIST_DEPTH),
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // model state: delay history, write pointer and register copies
  logic signed [SAMPLE_W-1:0]   left_hist  [HIST_DEPTH];
  logic signed [SAMPLE_W-1:0]   right_hist [HIST_DEPTH];
  logic [sfdi_pkg::DELAY_W-1:0] wr_pos;
  logic [sfdi_pkg::DELAY_W-1:0] tap_whole;
  logic [sfdi_pkg::FRAC_W-1:0]  tap_frac;
  logic [sfdi_pkg::FB_W-1:0]    fb_gain;
  logic [sfdi_pkg::WET_W-1:0]   wet_mix;

  stereo_frame_t frames_to_send [$];
  stereo_frame_t mixes_awaited  [$];

  int mismatch_count = 0;
  int stalls_asked   = 0;
  int stalls_done    = 0;
  bit sender_steady  = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] clip(input longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX[SAMPLE_W-1:0];
    if (v < SAMPLE_MIN) return SAMPLE_MIN[SAMPLE_W-1:0];
    return v[SAMPLE_W-1:0];
  endfunction

  // round half up, then floor
  function automatic longint round_q(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // one channel: interpolated tap, feedback value to store, mixed output
  function automatic void echo_channel(
    input  logic signed [SAMPLE_W-1:0] x,
    input  logic signed [SAMPLE_W-1:0] near_tap,
    input  logic signed [SAMPLE_W-1:0] far_tap,
    output logic signed [SAMPLE_W-1:0] fed,
    output logic signed [SAMPLE_W-1:0] mixed
  );
    longint xs, y0, y1, f, wet, fb, delayed;
    xs  = longint'(x);
    y0  = longint'(near_tap);
    y1  = longint'(far_tap);
    f   = longint'(tap_frac);
    fb  = longint'(fb_gain);
    wet = longint'(wet_mix);
    if (wet > longint'(sfdi_pkg::UNITY_Q16)) wet = longint'(sfdi_pkg::UNITY_Q16);
    delayed = round_q(y0 * (sfdi_pkg::UNITY_Q16 - f) + y1 * f, sfdi_pkg::FRAC_W);
    fed     = clip(xs + round_q(delayed * fb, sfdi_pkg::FB_W));
    mixed   = clip(round_q(xs * (sfdi_pkg::UNITY_Q16 - wet) + delayed * wet,
                           sfdi_pkg::FRAC_W));
  endfunction

  // advance the model by one frame and queue the mix it should produce
  task automatic predict_echo_mix(input stereo_frame_t frame);
    logic [sfdi_pkg::DELAY_W-1:0] d, t0, t1;
    logic signed [SAMPLE_W-1:0]   l_fed, r_fed;
    stereo_frame_t                mix;
    d  = (tap_whole > sfdi_pkg::DELAY_W'(HIST_DEPTH - 2)) ?
         sfdi_pkg::DELAY_W'(HIST_DEPTH - 2) : tap_whole;
    t0 = wr_pos - d - 16'd1;
    t1 = wr_pos - d - 16'd2;
    echo_channel(frame.left, left_hist[t0], left_hist[t1], l_fed, mix.left);
    echo_channel(frame.right, right_hist[t0], right_hist[t1], r_fed, mix.right);
    left_hist[wr_pos]  = l_fed;
    right_hist[wr_pos] = r_fed;
    wr_pos = wr_pos + 16'd1;
    mixes_awaited.push_back(mix);
  endtask

  task automatic wipe_history();
    foreach (left_hist[i]) begin
      left_hist[i]  = '0;
      right_hist[i] = '0;
    end
  endtask

  // register write followed by a read-back of the same register
  task automatic write_reg(input sfdi_pkg::sfdi_reg_t idx,
                           input logic [sfdi_pkg::PDATA_W-1:0] value);
    logic [sfdi_pkg::PDATA_W-1:0] kept;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      sfdi_pkg::REG_DELAY_WHOLE: begin
        tap_whole = value[sfdi_pkg::DELAY_W-1:0];
        kept      = sfdi_pkg::PDATA_W'(tap_whole);
        wipe_history();
      end
      sfdi_pkg::REG_DELAY_FRACTION: begin
        tap_frac = value[sfdi_pkg::FRAC_W-1:0];
        kept     = sfdi_pkg::PDATA_W'(tap_frac);
        wipe_history();
      end
      sfdi_pkg::REG_FEEDBACK_GAIN: begin
        fb_gain = value[sfdi_pkg::FB_W-1:0];
        kept    = sfdi_pkg::PDATA_W'(fb_gain);
      end
      default: begin
        wet_mix = value[sfdi_pkg::WET_W-1:0];
        kept    = sfdi_pkg::PDATA_W'(wet_mix);
      end
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== kept)
      flag_mismatch($sformatf("%s reads back %0h, wrote %0h", idx.name(), prdata, kept));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly small delays so feedback builds up, with the edges mixed in
  function automatic logic [sfdi_pkg::PDATA_W-1:0] pick_setting(
    input sfdi_pkg::sfdi_reg_t idx
  );
    logic [sfdi_pkg::PDATA_W-1:0] v;
    case (idx)
      sfdi_pkg::REG_DELAY_WHOLE: begin
        case ($urandom_range(0, 7))
          0:       v = 32'd0;
          1:       v = HIST_DEPTH - 2;
          2:       v = 32'hFFFF;
          3:       v = $urandom;
          default: v = $urandom_range(0, 48);
        endcase
      end
      sfdi_pkg::REG_DELAY_FRACTION: begin
        case ($urandom_range(0, 4))
          0:       v = 32'd0;
          1:       v = 32'hFFFF;
          2:       v = 32'h8000;
          default: v = $urandom;
        endcase
      end
      sfdi_pkg::REG_FEEDBACK_GAIN: begin
        case ($urandom_range(0, 3))
          0:       v = 32'd0;
          1:       v = 32'h7FFF;
          default: v = $urandom;
        endcase
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       v = 32'd0;
          1:       v = sfdi_pkg::UNITY_Q16;
          2:       v = $urandom_range(sfdi_pkg::UNITY_Q16 + 1, 32'h1FFFF);
          default: v = $urandom_range(0, sfdi_pkg::UNITY_Q16);
        endcase
        if ($urandom_range(0, 3) == 0)
          v[31:sfdi_pkg::WET_W] = (32 - sfdi_pkg::WET_W)'($urandom);
      end
    endcase
    return v;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX[SAMPLE_W-1:0];
      1:       return SAMPLE_MIN[SAMPLE_W-1:0];
      2:       return SAMPLE_W'($urandom_range(0, 64));
      3:       return -SAMPLE_W'($urandom_range(0, 64));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic void push_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
    stereo_frame_t f;
    f.left  = l;
    f.right = r;
    frames_to_send.push_back(f);
  endfunction

  // wait until nothing is queued or outstanding, then let the write-back finish
  task automatic drain();
    while (frames_to_send.size() != 0 || mixes_awaited.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // sender: bursts of random length with random gaps, item held until taken
  int gap_left   = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      gap_left   = 0;
      burst_left = 0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (in_bus.valid) begin
        predict_echo_mix(frames_to_send[0]);
        void'(frames_to_send.pop_front());
      end
      if (gap_left > 0 && !sender_steady) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (frames_to_send.size() == 0) begin
        in_bus.valid <= 1'b0;
      end else begin
        in_bus.valid    <= 1'b1;
        in_bus.left_in  <= frames_to_send[0].left;
        in_bus.right_in <= frames_to_send[0].right;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(0, 6);
        end
      end
    end
  end

  // receiver: rotating stall pattern, plus a long hold-off on request
  logic [7:0]    stall_pat = 8'hFF;
  int            pat_age   = 0;
  int            hold_left = 0;
  stereo_frame_t got_mix;
  stereo_frame_t want_mix;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got_mix.left  = out_bus.left_out;
        got_mix.right = out_bus.right_out;
        if (mixes_awaited.size() == 0) begin
          flag_mismatch($sformatf("unexpected item L=%0d R=%0d", got_mix.left, got_mix.right));
        end else begin
          want_mix = mixes_awaited.pop_front();
          if (got_mix.left !== want_mix.left)
            flag_mismatch($sformatf("left_out %0d, want %0d", got_mix.left, want_mix.left));
          if (got_mix.right !== want_mix.right)
            flag_mismatch($sformatf("right_out %0d, want %0d", got_mix.right, want_mix.right));
        end
      end
      if (stalls_done != stalls_asked) begin
        stalls_done = stalls_asked;
        hold_left   = LONG_STALL;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        stall_pat = {stall_pat[0], stall_pat[7:1]};
        pat_age++;
        if (pat_age >= 48) begin
          pat_age   = 0;
          stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
          if (stall_pat == 8'h00) stall_pat = 8'h01;
        end
        out_bus.ready <= stall_pat[0];
      end
    end
  end

  // watchdog on cycles in which no item is accepted or delivered
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("stereo_feedback_delay_interp verification failed");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    rst_n           = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.left_in  = '0;
    in_bus.right_in = '0;
    out_bus.ready   = 1'b0;
    wr_pos          = '0;
    tap_whole       = '0;
    tap_frac        = '0;
    fb_gain         = '0;
    wet_mix         = sfdi_pkg::WET_W'(sfdi_pkg::UNITY_Q16);
    wipe_history();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: fully wet, no feedback, output is the previous frame
    push_frame(SAMPLE_MAX[SAMPLE_W-1:0], SAMPLE_MIN[SAMPLE_W-1:0]);
    push_frame(SAMPLE_MIN[SAMPLE_W-1:0], SAMPLE_MAX[SAMPLE_W-1:0]);
    push_frame(24'h000000, 24'hFFFFFF);
    push_frame(24'h555555, 24'hAAAAAA);
    push_frame(24'hAAAAAA, 24'h555555);
    push_frame(24'h000001, 24'h000000);

    // full feedback with near-one fraction and an oversized wet gain:
    // the stored value saturates
    drain();
    write_reg(sfdi_pkg::REG_DELAY_WHOLE, 32'd1);
    write_reg(sfdi_pkg::REG_DELAY_FRACTION, 32'hFFFF);
    write_reg(sfdi_pkg::REG_FEEDBACK_GAIN, 32'h7FFF);
    write_reg(sfdi_pkg::REG_WET_GAIN, 32'hFFFF_FFFF);
    @(negedge clk);
    repeat (3) begin
      push_frame(SAMPLE_MAX[SAMPLE_W-1:0], SAMPLE_MIN[SAMPLE_W-1:0]);
      push_frame(SAMPLE_MAX[SAMPLE_W-1:0], SAMPLE_MIN[SAMPLE_W-1:0]);
    end

    // delay past the end of the store, fully dry
    drain();
    write_reg(sfdi_pkg::REG_DELAY_WHOLE, 32'hFFFF);
    write_reg(sfdi_pkg::REG_DELAY_FRACTION, 32'd0);
    write_reg(sfdi_pkg::REG_FEEDBACK_GAIN, 32'd0);
    write_reg(sfdi_pkg::REG_WET_GAIN, 32'd0);
    @(negedge clk);
    push_frame(SAMPLE_MIN[SAMPLE_W-1:0], SAMPLE_MAX[SAMPLE_W-1:0]);
    push_frame(24'h123456, 24'hEDCBA9);
    push_frame(24'hFFFFFF, 24'h000001);
    push_frame(SAMPLE_MAX[SAMPLE_W-1:0], SAMPLE_MIN[SAMPLE_W-1:0]);

    // half-sample interpolation, half feedback, half wet
    drain();
    write_reg(sfdi_pkg::REG_DELAY_WHOLE, 32'd2);
    write_reg(sfdi_pkg::REG_DELAY_FRACTION, 32'h8000);
    write_reg(sfdi_pkg::REG_FEEDBACK_GAIN, 32'h4000);
    write_reg(sfdi_pkg::REG_WET_GAIN, 32'h8000);
    @(negedge clk);
    push_frame(24'h000003, 24'hFFFFFD);
    push_frame(24'h400000, 24'hC00000);
    push_frame(24'h000001, 24'hFFFFFF);
    push_frame(SAMPLE_MAX[SAMPLE_W-1:0], SAMPLE_MIN[SAMPLE_W-1:0]);
    push_frame(24'h000000, 24'h000000);
    push_frame(24'h000000, 24'h000000);

    // random segments, each under its own settings
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      bit touched;
      int count;
      drain();
      touched = 1'b0;
      for (int r = 0; r < 4; r++) begin
        if ($urandom_range(0, 1) == 1) begin
          write_reg(sfdi_pkg::sfdi_reg_t'(r), pick_setting(sfdi_pkg::sfdi_reg_t'(r)));
          touched = 1'b1;
        end
      end
      if (!touched) write_reg(sfdi_pkg::REG_WET_GAIN, pick_setting(sfdi_pkg::REG_WET_GAIN));
      @(negedge clk);
      sender_steady = (seg == 2 || seg == 9) || ($urandom_range(0, 3) == 0);
      count = $urandom_range(90, 150);
      repeat (count) push_frame(pick_sample(), pick_sample());
      // long receiver hold-off while the sender keeps offering
      if (seg == 2 || seg == 9) stalls_asked = stalls_asked + 1;
    end

    drain();
    while (mixes_awaited.size() != 0) begin
      want_mix = mixes_awaited.pop_front();
      flag_mismatch($sformatf("missing item L=%0d R=%0d", want_mix.left, want_mix.right));
    end
    if (mismatch_count == 0) begin
      $display("stereo_feedback_delay_interp verification clean");
    end else begin
      $display("stereo_feedback_delay_interp verification failed");
    end
    $finish;
  end

endmodule
